// File: sv/mitpb_pkg.sv
package mitpb_pkg;

    // default frame geometry
    localparam int DEF_IMAGE_HEIGHT = 60;
    localparam int DEF_IMAGE_WIDTH  = 80;

    // display command bytes
    localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
    localparam logic [1:0] COL_HIGH_TAG  = 2'b10;

    localparam int PAGE_W     = 3;
    localparam int COLUMN_W   = 7;
    localparam int PIXEL_W    = 8;
    localparam int BAND_ROWS  = 8;
    localparam int M_TDATA_W  = 40;

    // one drain byte waiting for its frame store read
    typedef struct packed {
        logic [PAGE_W-1:0]    page;
        logic [COLUMN_W-1:0]  column;
        logic [BAND_ROWS-1:0] row_mask;
        logic                 last;
    } band_t;

    // packed result fields, highest bit first
    typedef struct packed {
        logic [M_TDATA_W-36:0] pad;
        logic [7:0]            pixel_byte;
        logic [3:0]            column_low_command;
        logic [4:0]            column_high_command;
        logic [7:0]            page_command;
        logic [COLUMN_W-1:0]   column_index;
        logic [PAGE_W-1:0]     page_index;
    } result_t;

endpackage

// File: sv/mitpb_ram.sv
module mitpb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/mono_image_to_page_bytes.sv
// Packs a monochrome camera frame into page bytes for a page-addressed display.
// s_ channel: one transaction per item; s_tuser selects a pixel load (0) or a
// drain tick (1), s_tdata carries the pixel. Pixels fill the frame row by row
// and each is stored as one bit (set when it equals black_level). Once the
// frame is full, each drain tick yields one m_ transaction: the byte of one
// 8-row band of one column plus its page and column address commands, full
// bands column by column first, then the leftover band; m_tlast marks the
// final byte, after which the next pixel starts a new frame.
// Pixels while the frame is full and drain ticks before it is full give nothing.
// cfg channel writes black_level; it is always ready.
// Throughput: one item per cycle while the result register is not stalled. A drain
// tick's byte reaches m_ through the registered read of the frame store (one 1-bit
// RAM per row within a band) and then the result register.
// Reset clears all counters and black_level; the frame store is not cleared.
// When m_tready is low the result register holds; while the read stage is empty,
// pixels keep being taken and one more drain tick is taken into it, and then
// s_tready drops until the result moves on.
module mono_image_to_page_bytes #(
    parameter int IMAGE_HEIGHT = mitpb_pkg::DEF_IMAGE_HEIGHT,
    parameter int IMAGE_WIDTH  = mitpb_pkg::DEF_IMAGE_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_value
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] page_index, [9:3] column_index, [17:10] page_command,
    // [22:18] column_high_command, [26:23] column_low_command,
    // [34:27] pixel_byte, [39:35] zero
    output logic [39:0] m_tdata,
    output logic        m_tlast,   // last_byte
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int FULL_PAGES = IMAGE_HEIGHT / 8;
    localparam int LEFT_ROWS  = IMAGE_HEIGHT % 8;
    localparam int BANDS      = (IMAGE_HEIGHT + 7) / 8;
    localparam int DEPTH      = BANDS * IMAGE_WIDTH;
    localparam int AW         = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int ROW_W      = IMAGE_HEIGHT > 1 ? $clog2(IMAGE_HEIGHT) : 1;
    localparam int COL_W      = IMAGE_WIDTH > 1 ? $clog2(IMAGE_WIDTH) : 1;
    localparam logic [2:0] LAST_PAGE = 3'(FULL_PAGES > 0 ? FULL_PAGES - 1 : 0);
    localparam logic [2:0] LEFT_PAGE = 3'(FULL_PAGES);
    localparam logic [7:0] LEFT_MASK = 8'((9'd1 << LEFT_ROWS) - 9'd1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(IMAGE_HEIGHT - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(IMAGE_WIDTH - 1);

    logic [7:0]       black_level_reg;
    logic [ROW_W-1:0] load_row_reg, load_row_next;
    logic [COL_W-1:0] load_col_reg, load_col_next;
    logic             frame_full_reg, frame_full_next;
    logic [COL_W-1:0] drain_col_reg, drain_col_next;
    logic [2:0]       drain_page_reg, drain_page_next;
    logic             drain_left_reg, drain_left_next;

    logic               s_fire, load_fire, drain_fire, advance;
    logic               left_mode, drain_last;
    logic [2:0]         drain_page_sel;
    logic [2:0]         load_lane;
    logic [AW-1:0]      load_addr, drain_addr;
    logic [7:0]         lane_we, lane_rdata;
    logic               pixel_bit;
    mitpb_pkg::band_t   band;
    mitpb_pkg::band_t   p1_reg;
    logic               p1_valid_reg;
    logic               m_valid_reg;
    mitpb_pkg::result_t m_data_reg;
    logic               m_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            black_level_reg <= '0;
        end else if (cfg_valid) begin
            black_level_reg <= cfg_data;
        end
    end

    assign advance    = !m_valid_reg || m_tready;
    assign s_tready   = !p1_valid_reg || advance;
    assign s_fire     = s_tvalid && s_tready;
    assign load_fire  = s_fire && !s_tuser && !frame_full_reg;
    assign drain_fire = s_fire && s_tuser && frame_full_reg;

    // drain position decode
    assign left_mode      = drain_left_reg || (FULL_PAGES == 0);
    assign drain_page_sel = left_mode ? LEFT_PAGE : drain_page_reg;
    assign drain_last     = (drain_col_reg == LAST_COL) &&
                            (left_mode || ((LEFT_ROWS == 0) && (drain_page_reg == LAST_PAGE)));

    always_comb begin
        band.page     = drain_page_sel;
        band.column   = 7'(drain_col_reg);
        band.row_mask = left_mode ? LEFT_MASK : 8'hFF;
        band.last     = drain_last;
    end

    always_comb begin
        load_row_next   = load_row_reg;
        load_col_next   = load_col_reg;
        frame_full_next = frame_full_reg;
        drain_col_next  = drain_col_reg;
        drain_page_next = drain_page_reg;
        drain_left_next = drain_left_reg;
        if (load_fire) begin
            if (load_col_reg == LAST_COL) begin
                load_col_next = '0;
                if (load_row_reg == LAST_ROW) begin
                    load_row_next   = '0;
                    frame_full_next = 1'b1;
                end else begin
                    load_row_next = load_row_reg + 1'b1;
                end
            end else begin
                load_col_next = load_col_reg + 1'b1;
            end
        end
        if (drain_fire) begin
            if (drain_last) begin
                frame_full_next = 1'b0;
                drain_col_next  = '0;
                drain_page_next = '0;
                drain_left_next = 1'b0;
                load_row_next   = '0;
                load_col_next   = '0;
            end else if (left_mode) begin
                drain_left_next = 1'b1;
                drain_col_next  = drain_col_reg + 1'b1;
            end else if (drain_page_reg == LAST_PAGE) begin
                drain_page_next = '0;
                if (drain_col_reg == LAST_COL) begin
                    drain_col_next  = '0;
                    drain_left_next = (LEFT_ROWS != 0);
                end else begin
                    drain_col_next = drain_col_reg + 1'b1;
                end
            end else begin
                drain_page_next = drain_page_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_row_reg   <= '0;
            load_col_reg   <= '0;
            frame_full_reg <= 1'b0;
            drain_col_reg  <= '0;
            drain_page_reg <= '0;
            drain_left_reg <= 1'b0;
        end else begin
            load_row_reg   <= load_row_next;
            load_col_reg   <= load_col_next;
            frame_full_reg <= frame_full_next;
            drain_col_reg  <= drain_col_next;
            drain_page_reg <= drain_page_next;
            drain_left_reg <= drain_left_next;
        end
    end

    // frame store: lane k holds row 8*band+k, address band*width+column
    assign load_lane  = 3'(load_row_reg);
    assign load_addr  = AW'(load_row_reg >> 3) * AW'(IMAGE_WIDTH) + AW'(load_col_reg);
    assign drain_addr = AW'(drain_page_sel) * AW'(IMAGE_WIDTH) + AW'(drain_col_reg);
    assign pixel_bit  = (s_tdata == black_level_reg);

    for (genvar k = 0; k < 8; k++) begin : g_lane
        assign lane_we[k] = load_fire && (load_lane == 3'(k));
        mitpb_ram #(
            .WIDTH (1),
            .DEPTH (DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (lane_we[k]),
            .waddr (load_addr),
            .wdata (pixel_bit),
            .re    (drain_fire),
            .raddr (drain_addr),
            .rdata (lane_rdata[k])
        );
    end

    // read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= drain_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain_fire) begin
            p1_reg <= band;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && p1_valid_reg) begin
            m_data_reg.pad                 <= '0;
            m_data_reg.page_index          <= p1_reg.page;
            m_data_reg.column_index        <= p1_reg.column;
            m_data_reg.page_command        <= mitpb_pkg::PAGE_CMD_BASE + 8'(p1_reg.page);
            m_data_reg.column_high_command <= {mitpb_pkg::COL_HIGH_TAG, p1_reg.column[6:4]};
            m_data_reg.column_low_command  <= p1_reg.column[3:0];
            m_data_reg.pixel_byte          <= lane_rdata & p1_reg.row_mask;
            m_last_reg                     <= p1_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // no input is taken while the read stage waits on a stalled result register
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while read stage is blocked");

    // the final byte of a frame reopens loading
    a_last_clears_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (drain_fire && drain_last) |=>
            (!frame_full_reg && load_row_reg == '0 && load_col_reg == '0))
        else $error("frame not released after last byte");

    // no store write once the frame is complete
    a_no_write_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_full_reg |-> (lane_we == '0))
        else $error("frame store written while full");

    // row and column counters stay inside the frame
    a_counters_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_col_reg <= LAST_COL) && (load_row_reg <= LAST_ROW) &&
        (drain_col_reg <= LAST_COL))
        else $error("frame counter out of range");

endmodule

// File: bench/mono_image_to_page_bytes_test.sv
module mono_image_to_page_bytes_test;

    localparam int IMG_H       = mitpb_pkg::DEF_IMAGE_HEIGHT;
    localparam int IMG_W       = mitpb_pkg::DEF_IMAGE_WIDTH;
    localparam int FULL_BANDS  = IMG_H / 8;
    localparam int LEFT_ROWS   = IMG_H % 8;
    localparam int SETTLE      = 6;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_PRINTS  = 40;

    localparam bit KIND_PIXEL = 1'b0;
    localparam bit KIND_DRAIN = 1'b1;

    localparam logic [7:0] PAGE_ADDR_CMD = 8'hB0;
    localparam logic [4:0] COL_HIGH_CMD  = 5'h10;

    typedef struct packed {
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] page_cmd;
        logic [4:0] col_high;
        logic [3:0] col_low;
        logic [7:0] dots;
        logic       last;
    } page_byte_t;

    class page_byte_scoreboard;
        bit          lit [IMG_H][IMG_W];
        bit [7:0]    black_level;
        int unsigned load_row;
        int unsigned load_col;
        int unsigned drain_col;
        int unsigned drain_page;
        bit          full;
        bit          leftover;
        page_byte_t  waiting [$];

        function new();
            foreach (lit[r, c]) lit[r][c] = 1'b0;
            black_level = 8'h00;
            load_row    = 0;
            load_col    = 0;
            drain_col   = 0;
            drain_page  = 0;
            full        = 1'b0;
            leftover    = 1'b0;
        endfunction

        function void set_black(bit [7:0] v);
            black_level = v;
        endfunction

        function int pending();
            return waiting.size();
        endfunction

        function void note_input(bit kind, bit [7:0] pix);
            page_byte_t  e;
            int unsigned page;
            int unsigned col;
            int unsigned rows;
            int unsigned k;
            bit [7:0]    dots;
            bit          last;
            if (kind == KIND_PIXEL) begin
                if (full) return;
                lit[load_row][load_col] = (pix == black_level);
                load_col++;
                if (load_col >= IMG_W) begin
                    load_col = 0;
                    load_row++;
                    if (load_row >= IMG_H) begin
                        load_row = 0;
                        full     = 1'b1;
                    end
                end
                return;
            end
            // drain tick before the frame is complete gives nothing
            if (!full) return;
            if (FULL_BANDS == 0) leftover = 1'b1;
            col = drain_col;
            if (leftover) begin
                page = FULL_BANDS;
                rows = LEFT_ROWS;
                last = (col + 1 >= IMG_W);
                drain_col++;
            end else begin
                page = drain_page;
                rows = 8;
                last = (LEFT_ROWS == 0) && (col + 1 >= IMG_W) && (page + 1 >= FULL_BANDS);
                drain_page++;
                if (drain_page >= FULL_BANDS) begin
                    drain_page = 0;
                    drain_col++;
                    if (drain_col >= IMG_W) begin
                        drain_col = 0;
                        if (LEFT_ROWS != 0) leftover = 1'b1;
                    end
                end
            end
            dots = 8'h00;
            for (k = 0; k < rows; k++) begin
                if (page * 8 + k < IMG_H && lit[page * 8 + k][col]) dots[k] = 1'b1;
            end
            if (last) begin
                full       = 1'b0;
                drain_col  = 0;
                drain_page = 0;
                leftover   = 1'b0;
                load_row   = 0;
                load_col   = 0;
            end
            e.page     = page[2:0];
            e.column   = col[6:0];
            e.page_cmd = PAGE_ADDR_CMD + {5'b0, page[2:0]};
            e.col_high = COL_HIGH_CMD | {2'b0, e.column[6:4]};
            e.col_low  = e.column[3:0];
            e.dots     = dots;
            e.last     = last;
            waiting.push_back(e);
        endfunction

        function bit check_result(mitpb_pkg::result_t got, logic got_last, output string why);
            page_byte_t e;
            why = "";
            if (waiting.size() == 0) begin
                why = $sformatf("byte with none expected, page %0d column %0d",
                                got.page_index, got.column_index);
                return 1'b0;
            end
            e = waiting.pop_front();
            if (got.page_index !== e.page)
                why = {why, $sformatf(" page_index %0h/%0h", got.page_index, e.page)};
            if (got.column_index !== e.column)
                why = {why, $sformatf(" column_index %0h/%0h", got.column_index, e.column)};
            if (got.page_command !== e.page_cmd)
                why = {why, $sformatf(" page_command %0h/%0h", got.page_command, e.page_cmd)};
            if (got.column_high_command !== e.col_high)
                why = {why, $sformatf(" column_high_command %0h/%0h",
                                      got.column_high_command, e.col_high)};
            if (got.column_low_command !== e.col_low)
                why = {why, $sformatf(" column_low_command %0h/%0h",
                                      got.column_low_command, e.col_low)};
            if (got.pixel_byte !== e.dots)
                why = {why, $sformatf(" pixel_byte %0h/%0h", got.pixel_byte, e.dots)};
            if (got_last !== e.last)
                why = {why, $sformatf(" last_byte %0b/%0b", got_last, e.last)};
            if (got.pad !== '0)
                why = {why, " padding not zero"};
            if (why != "")
                why = {$sformatf("byte page %0d column %0d got/want:", e.page, e.column), why};
            return why == "";
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'h00;

    page_byte_scoreboard sb = new();
    int          error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sent_count  = 0;
    bit          calm        = 1'b0;

    mono_image_to_page_bytes dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic bit [7:0] pick_pixel(input bit [7:0] black);
        case ($urandom_range(0, 3))
            0, 1: return black;
            2: return 8'($urandom_range(0, 255));
            default: return black ^ (8'h01 << $urandom_range(0, 7));
        endcase
    endfunction

    // valid stays high between back-to-back transactions
    task automatic send_item(input bit kind, input bit [7:0] pix);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pix;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        sb.note_input(kind, pix);
        sent_count++;
        if (sent_count % 200 == 0) calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic cfg_write(input bit [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_black(v);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic run_frame(input bit [7:0] black, input bit directed);
        cfg_write(black);
        if (directed) begin
            repeat (3) send_item(KIND_DRAIN, 8'($urandom));
            send_item(KIND_PIXEL, 8'h00);
            send_item(KIND_PIXEL, 8'hFF);
            send_item(KIND_PIXEL, 8'h01);
            send_item(KIND_PIXEL, 8'h80);
            send_item(KIND_PIXEL, black);
            send_item(KIND_PIXEL, black ^ 8'h01);
        end
        while (!sb.full) begin
            // new black level between rows while nothing is in flight
            if (sb.load_col == 0 && sb.load_row % 20 == 10) begin
                wait_drained();
                cfg_write(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) < 2) send_item(KIND_DRAIN, 8'($urandom));
            send_item(KIND_PIXEL, pick_pixel(sb.black_level));
        end
        // pixels arriving on a full frame are dropped
        if (directed) repeat (2) send_item(KIND_PIXEL, pick_pixel(sb.black_level));
        while (sb.full) begin
            if ($urandom_range(0, 99) < 2) send_item(KIND_PIXEL, 8'($urandom));
            send_item(KIND_DRAIN, 8'($urandom));
        end
        repeat ($urandom_range(0, 2)) send_item(KIND_DRAIN, 8'($urandom));
        wait_drained();
    endtask

    initial begin
        int    stall;
        string why;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            if (!sb.check_result(mitpb_pkg::result_t'(m_tdata), m_tlast, why))
                report_mismatch(why);
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        run_frame(8'h00, 1'b1);
        // start of the next frame: drain ticks give nothing yet
        repeat (30) send_item(1'($urandom_range(0, 1)), 8'($urandom));
        wait_drained();
        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d bytes never arrived", sb.pending()));
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
sv/mitpb_pkg.sv
sv/mitpb_ram.sv
sv/mono_image_to_page_bytes.sv
bench/mono_image_to_page_bytes_test.sv
